FILE: rtl/amx_pkg.sv
// Shared constants and codes for the decimal accumulator machine.
`timescale 1ns / 1ps
package amx_pkg;

  localparam int STORE_WORDS = 100;
  localparam int WORD_BITS   = 32;
  localparam int ADDR_BITS   = $clog2(STORE_WORDS);
  localparam int STEP_BITS   = $clog2(WORD_BITS);
  localparam int CMD_BITS    = 2;
  localparam int STAT_BITS   = 3;

  localparam int OPC_BITS    = 6;
  localparam int DEC_BITS    = 13;
  localparam int DEC_LIMIT   = 4400;
  localparam int DEC_RECIP   = 5243;
  localparam int DEC_SHIFT   = 19;
  localparam int DEC_RADIX   = 100;

  typedef logic [CMD_BITS-1:0]  cmd_t;
  typedef logic [STAT_BITS-1:0] stat_t;
  typedef logic [OPC_BITS-1:0]  opc_t;

  localparam cmd_t CMD_LOAD    = 2'd0;
  localparam cmd_t CMD_EXEC    = 2'd1;
  localparam cmd_t CMD_RESTART = 2'd2;

  localparam stat_t ST_RUN     = 3'd0;
  localparam stat_t ST_HALT    = 3'd1;
  localparam stat_t ST_DIVZERO = 3'd2;
  localparam stat_t ST_BADOP   = 3'd3;
  localparam stat_t ST_RANGE   = 3'd4;

  localparam opc_t OP_READ       = 6'd10;
  localparam opc_t OP_WRITE      = 6'd11;
  localparam opc_t OP_LOAD       = 6'd20;
  localparam opc_t OP_STORE      = 6'd21;
  localparam opc_t OP_ADD        = 6'd30;
  localparam opc_t OP_SUB        = 6'd31;
  localparam opc_t OP_DIV        = 6'd32;
  localparam opc_t OP_MUL        = 6'd33;
  localparam opc_t OP_BRANCH     = 6'd40;
  localparam opc_t OP_BRANCHNEG  = 6'd41;
  localparam opc_t OP_BRANCHZERO = 6'd42;
  localparam opc_t OP_HALT       = 6'd43;

endpackage

FILE: rtl/amx_req_if.sv
// Request channel: command, store address and data word.
`timescale 1ns / 1ps
interface amx_req_if;
  logic                                  valid;
  logic                                  ready;
  amx_pkg::cmd_t                         cmd;
  logic [amx_pkg::ADDR_BITS-1:0]         address;
  logic signed [amx_pkg::WORD_BITS-1:0]  data;

  modport source (output valid, output cmd, output address, output data, input ready);
  modport sink   (input valid, input cmd, input address, input data, output ready);
endinterface

FILE: rtl/amx_rsp_if.sv
// Response channel: run status, output word, accumulator and counter.
`timescale 1ns / 1ps
interface amx_rsp_if;
  logic                                  valid;
  logic                                  ready;
  amx_pkg::stat_t                        status;
  logic                                  write_valid;
  logic signed [amx_pkg::WORD_BITS-1:0]  write_value;
  logic                                  read_taken;
  logic signed [amx_pkg::WORD_BITS-1:0]  acc_value;
  logic [amx_pkg::ADDR_BITS-1:0]         next_counter;

  modport source (output valid, output status, output write_valid, output write_value,
                  output read_taken, output acc_value, output next_counter, input ready);
  modport sink   (input valid, input status, input write_valid, input write_value,
                  input read_taken, input acc_value, input next_counter, output ready);
endinterface

FILE: rtl/accumulator_machine_executor_unit.sv
// Decimal accumulator machine: store, sequencer and shared arithmetic unit.
// Load, restart and ignored commands go from accept through S_RESP to the result.
// Execute: fetch, decode in S_DEC1 and S_DEC2, operand read, result; divide
// adds S_DIVPREP, the one-bit-per-cycle loop through the shared adder and
// S_DIVEND. Reset clears control state, then sweeps all 100 store words to
// zero with ready low.
`timescale 1ns / 1ps
module accumulator_machine_executor_unit (
  input  logic      clk,
  input  logic      rst,
  amx_req_if.sink   req,
  amx_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DEC1, S_DEC2, S_EXEC, S_DIVPREP, S_DIV, S_DIVEND, S_RESP
  } state_t;

  localparam int AluBits = amx_pkg::WORD_BITS + 1;

  state_t                             state;
  logic [amx_pkg::ADDR_BITS-1:0]      clr_addr;
  logic [amx_pkg::WORD_BITS-1:0]      mem [amx_pkg::STORE_WORDS];
  logic [amx_pkg::WORD_BITS-1:0]      rdata;
  logic [amx_pkg::WORD_BITS-1:0]      acc;
  logic [amx_pkg::ADDR_BITS-1:0]      pc;
  amx_pkg::stat_t                     status;
  logic [amx_pkg::WORD_BITS-1:0]      data_q;
  amx_pkg::opc_t                      opcode;
  logic [amx_pkg::DEC_BITS-1:0]       word_lo;
  logic                               bad_word;
  logic [amx_pkg::ADDR_BITS-1:0]      idx;
  logic                               pend_wv;
  logic [amx_pkg::WORD_BITS-1:0]      pend_wval;
  logic                               pend_rt;
  logic [amx_pkg::WORD_BITS-1:0]      div_d;
  logic [amx_pkg::WORD_BITS-1:0]      div_r;
  logic [amx_pkg::WORD_BITS-1:0]      div_q;
  logic [amx_pkg::STEP_BITS-1:0]      div_cnt;
  logic                               div_neg;

  logic                               accept;
  logic                               out_free;
  logic                               mem_we;
  logic [amx_pkg::ADDR_BITS-1:0]      mem_waddr;
  logic [amx_pkg::WORD_BITS-1:0]      mem_wdata;
  logic                               mem_re;
  logic [amx_pkg::ADDR_BITS-1:0]      mem_raddr;
  logic [AluBits-1:0]                 alu_a;
  logic [AluBits-1:0]                 alu_b;
  logic                               alu_sub;
  logic [AluBits-1:0]                 alu_sum;
  logic [AluBits-1:0]                 div_shift;
  logic [2*amx_pkg::DEC_BITS-1:0]     dec_prod;
  logic [amx_pkg::DEC_BITS-1:0]       dec_rem;
  logic [amx_pkg::WORD_BITS-1:0]      mul_lo;
  logic                               br_taken;
  logic                               pc_out;

  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;

  assign dec_prod  = rdata[amx_pkg::DEC_BITS-1:0] * amx_pkg::DEC_BITS'(amx_pkg::DEC_RECIP);
  assign dec_rem   = word_lo - amx_pkg::DEC_BITS'(opcode) * amx_pkg::DEC_BITS'(amx_pkg::DEC_RADIX);
  assign mul_lo    = acc * rdata;
  assign div_shift = {div_r, div_q[amx_pkg::WORD_BITS-1]};
  assign pc_out    = pc >= amx_pkg::ADDR_BITS'(amx_pkg::STORE_WORDS);

  always_comb begin
    case (opcode)
      amx_pkg::OP_BRANCH:     br_taken = 1'b1;
      amx_pkg::OP_BRANCHNEG:  br_taken = acc[amx_pkg::WORD_BITS-1];
      amx_pkg::OP_BRANCHZERO: br_taken = (acc == '0);
      default:                br_taken = 1'b0;
    endcase
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_EXEC: begin
        if (opcode == amx_pkg::OP_DIV) begin
          alu_b   = {1'b0, rdata};
          alu_sub = rdata[amx_pkg::WORD_BITS-1];
        end else begin
          alu_a   = {1'b0, acc};
          alu_b   = {1'b0, rdata};
          alu_sub = (opcode == amx_pkg::OP_SUB);
        end
      end
      S_DIVPREP: begin
        alu_b   = {1'b0, acc};
        alu_sub = acc[amx_pkg::WORD_BITS-1];
      end
      S_DIV: begin
        alu_a   = div_shift;
        alu_b   = {1'b0, div_d};
        alu_sub = 1'b1;
      end
      S_DIVEND: begin
        alu_b   = {1'b0, div_q};
        alu_sub = div_neg;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + AluBits'(alu_sub);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = acc;
    mem_re    = 1'b0;
    mem_raddr = pc;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE: begin
        if (accept && req.cmd == amx_pkg::CMD_LOAD &&
            req.address < amx_pkg::ADDR_BITS'(amx_pkg::STORE_WORDS)) begin
          mem_we    = 1'b1;
          mem_waddr = req.address;
          mem_wdata = req.data;
        end
        mem_re = accept && req.cmd == amx_pkg::CMD_EXEC && status == amx_pkg::ST_RUN &&
                 !pc_out;
      end
      S_DEC2: begin
        mem_re    = !bad_word;
        mem_raddr = dec_rem[amx_pkg::ADDR_BITS-1:0];
      end
      S_EXEC: begin
        mem_we    = (opcode == amx_pkg::OP_READ) || (opcode == amx_pkg::OP_STORE);
        mem_wdata = (opcode == amx_pkg::OP_READ) ? data_q : acc;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      acc       <= '0;
      pc        <= '0;
      status    <= amx_pkg::ST_RUN;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_RESP) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == amx_pkg::ADDR_BITS'(amx_pkg::STORE_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            pend_wv   <= 1'b0;
            pend_wval <= '0;
            pend_rt   <= 1'b0;
            data_q    <= req.data;
            state     <= S_RESP;
            case (req.cmd)
              amx_pkg::CMD_EXEC: begin
                if (status == amx_pkg::ST_RUN) begin
                  if (pc_out) begin
                    status <= amx_pkg::ST_RANGE;
                  end else begin
                    state <= S_DEC1;
                  end
                end
              end
              amx_pkg::CMD_RESTART: begin
                pc     <= '0;
                acc    <= '0;
                status <= amx_pkg::ST_RUN;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_DEC1: begin
          pc       <= pc + 1'b1;
          opcode   <= dec_prod[amx_pkg::DEC_SHIFT +: amx_pkg::OPC_BITS];
          word_lo  <= rdata[amx_pkg::DEC_BITS-1:0];
          bad_word <= rdata[amx_pkg::WORD_BITS-1] ||
                      (rdata >= amx_pkg::WORD_BITS'(amx_pkg::DEC_LIMIT));
          state    <= S_DEC2;
        end
        S_DEC2: begin
          idx <= dec_rem[amx_pkg::ADDR_BITS-1:0];
          if (bad_word) begin
            status <= amx_pkg::ST_BADOP;
            state  <= S_RESP;
          end else begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_RESP;
          case (opcode)
            amx_pkg::OP_HALT: begin
              status <= amx_pkg::ST_HALT;
            end
            amx_pkg::OP_DIV: begin
              if (rdata == '0) begin
                status <= amx_pkg::ST_DIVZERO;
              end else begin
                div_d   <= alu_sum[amx_pkg::WORD_BITS-1:0];
                div_neg <= acc[amx_pkg::WORD_BITS-1] ^ rdata[amx_pkg::WORD_BITS-1];
                state   <= S_DIVPREP;
              end
            end
            amx_pkg::OP_READ, amx_pkg::OP_WRITE, amx_pkg::OP_LOAD, amx_pkg::OP_STORE,
            amx_pkg::OP_ADD, amx_pkg::OP_SUB, amx_pkg::OP_MUL, amx_pkg::OP_BRANCH,
            amx_pkg::OP_BRANCHNEG, amx_pkg::OP_BRANCHZERO: begin
              if (opcode == amx_pkg::OP_READ) begin
                pend_rt <= 1'b1;
              end
              if (opcode == amx_pkg::OP_WRITE) begin
                pend_wv   <= 1'b1;
                pend_wval <= rdata;
              end
              if (opcode == amx_pkg::OP_LOAD) begin
                acc <= rdata;
              end
              if (opcode == amx_pkg::OP_ADD || opcode == amx_pkg::OP_SUB) begin
                acc <= alu_sum[amx_pkg::WORD_BITS-1:0];
              end
              if (opcode == amx_pkg::OP_MUL) begin
                acc <= mul_lo;
              end
              if (br_taken) begin
                pc <= idx;
              end else if (pc_out) begin
                status <= amx_pkg::ST_RANGE;
              end
            end
            default: begin
              status <= amx_pkg::ST_BADOP;
            end
          endcase
        end
        S_DIVPREP: begin
          div_q   <= alu_sum[amx_pkg::WORD_BITS-1:0];
          div_r   <= '0;
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (!alu_sum[AluBits-1]) begin
            div_r <= alu_sum[amx_pkg::WORD_BITS-1:0];
            div_q <= {div_q[amx_pkg::WORD_BITS-2:0], 1'b1};
          end else begin
            div_r <= div_shift[amx_pkg::WORD_BITS-1:0];
            div_q <= {div_q[amx_pkg::WORD_BITS-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == amx_pkg::STEP_BITS'(amx_pkg::WORD_BITS - 1)) begin
            state <= S_DIVEND;
          end
        end
        S_DIVEND: begin
          acc <= alu_sum[amx_pkg::WORD_BITS-1:0];
          if (pc_out) begin
            status <= amx_pkg::ST_RANGE;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= status;
            rsp.write_valid  <= pend_wv;
            rsp.write_value  <= pend_wval;
            rsp.read_taken   <= pend_rt;
            rsp.acc_value    <= acc;
            rsp.next_counter <= pc;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/amx_checker.sv
// Port-level checks for the accumulator machine, bound to the top level.
`timescale 1ns / 1ps
module amx_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input amx_pkg::stat_t                rsp_status,
  input logic                          rsp_write_valid,
  input logic [amx_pkg::WORD_BITS-1:0] rsp_write_value,
  input logic                          rsp_read_taken,
  input logic [amx_pkg::WORD_BITS-1:0] rsp_acc_value,
  input logic [amx_pkg::ADDR_BITS-1:0] rsp_next_counter
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_acc_value) && $stable(rsp_next_counter))
    else $error("response changed while stalled");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_write_valid |-> rsp_write_value == '0)
    else $error("output word set without a write");

  a_one_io: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_write_valid && rsp_read_taken))
    else $error("read and write in one item");

  a_range_stop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_next_counter >= amx_pkg::ADDR_BITS'(amx_pkg::STORE_WORDS)
      |-> rsp_status != amx_pkg::ST_RUN)
    else $error("counter out of range while running");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("channel active right after reset");

endmodule

bind accumulator_machine_executor_unit amx_checker u_amx_checker (
  .clk              (clk),
  .rst              (rst),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_write_valid  (rsp.write_valid),
  .rsp_write_value  (rsp.write_value),
  .rsp_read_taken   (rsp.read_taken),
  .rsp_acc_value    (rsp.acc_value),
  .rsp_next_counter (rsp.next_counter)
);
